/* rtl/sound_level_statistics_macros.svh */
// Assertion macros shared by the RTL that checks itself.
`ifndef SOUND_LEVEL_STATISTICS_MACROS_SVH
`define SOUND_LEVEL_STATISTICS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sls_pkg.sv */
`default_nettype none

package sls_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int LEVEL_W   = 33;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 2;
  localparam int SQ_SHIFT  = 14;

  localparam logic [1:0] MODE_EQ   = 2'd0;
  localparam logic [1:0] MODE_MAX  = 2'd1;
  localparam logic [1:0] MODE_MIN  = 2'd2;
  localparam logic [1:0] MODE_PEAK = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

  localparam logic [CFG_W-1:0] UPDATE_RESET = 25'd48000;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 25'd6000;

  typedef struct packed {
    logic load;
    logic square;
    logic accum;
    logic div_start;
    logic wrap;
  } sls_cmd_t;

  typedef struct packed {
    logic win_done;
    logic per_done;
    logic need_div;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sls_status_t;

endpackage

`default_nettype wire

/* rtl/sls_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in LEVEL_W bits, so the high dividend bits start out as the remainder.
module sls_div
  import sls_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [LEVEL_W+COUNT_BITS-1:0]   num,
  input  wire logic [COUNT_BITS:0]             den,
  output logic                                 busy,
  output logic                                 done,
  output logic [LEVEL_W-1:0]                   quot
);

  localparam int CW     = COUNT_BITS + 1;
  localparam int NUM_W  = LEVEL_W + COUNT_BITS;
  localparam int STEP_W = $clog2(LEVEL_W);

  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] rem_next;
  logic [LEVEL_W-1:0]    quo;
  logic [CW-1:0]         den_r;
  logic [CW-1:0]         trial;
  logic [CW-1:0]         trial_sub;
  logic                  ge;
  logic [STEP_W-1:0]     step;

  always_comb begin
    trial     = {rem, quo[LEVEL_W-1]};
    ge        = (trial >= den_r);
    trial_sub = trial - den_r;
    rem_next  = ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(LEVEL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NUM_W-1:LEVEL_W];
      quo   <= num[LEVEL_W-1:0];
      den_r <= den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[LEVEL_W-2:0], ge};
    end
  end

  assign quot = quo;

endmodule

`default_nettype wire

/* rtl/sls_dp.sv */
`default_nettype none

module sls_dp
  import sls_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_data,
  input  wire logic signed [SAMPLE_W-1:0]  sample,
  input  wire sls_cmd_t                    cmd,
  output sls_status_t                      st,
  output logic [LEVEL_W-1:0]               level,
  output logic                             empty_res,
  output logic                             out_valid,
  input  wire logic                        out_ready
);

  localparam int CW    = COUNT_BITS + 1;
  localparam int SUM_W = LEVEL_W + COUNT_BITS;
  localparam logic [CFG_W-1:0] TOP_LEN = CFG_W'(1) << COUNT_BITS;

  logic [1:0]             mode;
  logic [CFG_W-1:0]       upd_len;
  logic [CFG_W-1:0]       win_len;
  logic [CW-1:0]          ulim;
  logic [CW-1:0]          wlim;

  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS:0]   mag_n;
  logic [SAMPLE_W-1:0]    mag_in;
  logic [SAMPLE_W-1:0]    mag;
  logic [2*SAMPLE_W-1:0]  prod;
  logic [LEVEL_W-1:0]     sq;

  logic [SUM_W-1:0]       psum;
  logic [SUM_W-1:0]       wsum;
  logic [CW-1:0]          pcnt;
  logic [CW-1:0]          wcnt;
  logic [CW-1:0]          pcnt_inc;
  logic [CW-1:0]          wcnt_inc;
  logic [LEVEL_W-1:0]     extreme;
  logic                   window_seen;
  logic                   win_done;
  logic                   per_done;

  logic [LEVEL_W-1:0]     ext_start;
  logic [LEVEL_W-1:0]     ext_win;
  logic                   seen_new;
  logic                   windowed;
  logic                   per_wrap;

  logic [SUM_W-1:0]       div_num;
  logic [CW-1:0]          div_den;
  logic [LEVEL_W-1:0]     quot;
  logic                   div_busy;
  logic                   div_done;

  // Zero acts as one, oversize lengths clamp to the counter range.
  always_comb begin
    if (upd_len == '0) begin
      ulim = CW'(1);
    end else if (upd_len > TOP_LEN) begin
      ulim = TOP_LEN[CW-1:0];
    end else begin
      ulim = upd_len[CW-1:0];
    end
    if (win_len == '0) begin
      wlim = CW'(1);
    end else if (win_len > TOP_LEN) begin
      wlim = TOP_LEN[CW-1:0];
    end else begin
      wlim = win_len[CW-1:0];
    end
  end

  // Magnitude of the narrow sample, scaled up to full 24-bit range.
  always_comb begin
    raw    = sample[SAMPLE_BITS-1:0];
    mag_n  = raw[SAMPLE_BITS-1] ? (~{1'b0, raw} + 1'b1) : {1'b0, raw};
    mag_in = SAMPLE_W'(mag_n) << (SAMPLE_W - SAMPLE_BITS);
    prod   = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= mag_in;
    end
    if (cmd.square) begin
      sq <= prod[SQ_SHIFT +: LEVEL_W];
    end
  end

  assign pcnt_inc = pcnt + 1'b1;
  assign wcnt_inc = wcnt + 1'b1;
  assign windowed = (mode == MODE_MAX) || (mode == MODE_MIN);
  assign ext_start = (mode == MODE_MIN) ? '1 : '0;

  assign div_num = (mode == MODE_EQ) ? psum : wsum;
  assign div_den = (mode == MODE_EQ) ? pcnt : wcnt;

  // Window result is folded in before the period closes.
  always_comb begin
    ext_win = extreme;
    if (win_done && (mode == MODE_MAX) && (quot > extreme)) begin
      ext_win = quot;
    end
    if (win_done && (mode == MODE_MIN) && (quot < extreme)) begin
      ext_win = quot;
    end
    seen_new = window_seen | win_done;
  end

  assign per_wrap = cmd.wrap && per_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_EQ;
      upd_len     <= UPDATE_RESET;
      win_len     <= WINDOW_RESET;
      psum        <= '0;
      wsum        <= '0;
      pcnt        <= '0;
      wcnt        <= '0;
      extreme     <= '0;
      window_seen <= 1'b0;
      win_done    <= 1'b0;
      per_done    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: begin
          mode        <= cfg_data[1:0];
          psum        <= '0;
          wsum        <= '0;
          pcnt        <= '0;
          wcnt        <= '0;
          window_seen <= 1'b0;
          extreme     <= (cfg_data[1:0] == MODE_MIN) ? '1 : '0;
        end
        REG_UPDATE: upd_len <= cfg_data;
        REG_WINDOW: win_len <= cfg_data;
        default: ;
      endcase
    end else if (cmd.accum) begin
      psum     <= psum + SUM_W'(sq);
      wsum     <= wsum + SUM_W'(sq);
      pcnt     <= pcnt_inc;
      wcnt     <= wcnt_inc;
      win_done <= (wcnt_inc >= wlim);
      per_done <= (pcnt_inc >= ulim);
      if ((mode == MODE_PEAK) && (LEVEL_W'(mag) > extreme)) begin
        extreme <= LEVEL_W'(mag);
      end
    end else if (cmd.wrap) begin
      if (win_done) begin
        wsum <= '0;
        wcnt <= '0;
      end
      if (per_done) begin
        psum        <= '0;
        pcnt        <= '0;
        extreme     <= ext_start;
        window_seen <= 1'b0;
      end else begin
        extreme     <= ext_win;
        window_seen <= seen_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (per_wrap) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (per_wrap) begin
      priority if (mode == MODE_EQ) begin
        level <= quot;
      end else if (mode == MODE_PEAK) begin
        level <= extreme;
      end else if (seen_new) begin
        level <= ext_win;
      end else begin
        level <= '0;
      end
      empty_res <= windowed && !seen_new;
    end
  end

  sls_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quot (quot)
  );

  always_comb begin
    st.win_done = win_done;
    st.per_done = per_done;
    st.need_div = ((mode == MODE_EQ) && per_done) || (windowed && win_done);
    st.div_busy = div_busy;
    st.div_done = div_done;
    st.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

/* rtl/sls_ctrl.sv */
`default_nettype none

module sls_ctrl
  import sls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sls_status_t st,
  output sls_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_CHECK,
    S_DIV,
    S_WRAP
  } state_t;

  state_t state;

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.square    = (state == S_SQUARE);
    cmd.accum     = (state == S_ACCUM);
    cmd.div_start = (state == S_CHECK) && st.need_div;
    // Hold the period result until the output register frees up.
    cmd.wrap      = (state == S_WRAP) && (!st.per_done || st.out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SQUARE;
        end
        S_SQUARE: state <= S_ACCUM;
        S_ACCUM:  state <= S_CHECK;
        S_CHECK: begin
          priority if (st.need_div) begin
            state <= S_DIV;
          end else if (st.win_done || st.per_done) begin
            state <= S_WRAP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (st.div_done) state <= S_WRAP;
        end
        S_WRAP: begin
          if (cmd.wrap) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/sound_level_statistics.sv */
// Channel  Direction  Transfer on            Payload
// cfg      in         cfg_valid & cfg_ready  cfg_index, cfg_data
// in       in         in_valid & in_ready    sample
// out      out        out_valid & out_ready  level, empty_res
//
// Between sample transfers the controller steps through S_SQUARE, S_ACCUM
// and S_CHECK, adds S_WRAP when a window or period closes, and S_DIV before
// it when a mean is needed: the restoring divider produces one quotient bit
// per cycle (33 steps). Reset is synchronous; there is no clearing pass.
// A new sample is taken while a result waits; a period end holds until the
// output register is free. cfg_ready is always high.
`default_nettype none

`include "sound_level_statistics_macros.svh"

module sound_level_statistics
  import sls_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [SAMPLE_W-1:0]  sample,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [LEVEL_W-1:0]               level,
  output logic                             empty_res
);

  sls_cmd_t    cmd;
  sls_status_t st;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  sls_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  sls_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sample   (sample),
    .cmd      (cmd),
    .st       (st),
    .level    (level),
    .empty_res(empty_res),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  `SLS_ASSERT_NOW(a_div_start, clk, rst, cmd.div_start, st.need_div && !st.div_busy, "divide started without a pending mean")
  `SLS_ASSERT_NOW(a_ready_div, clk, rst, in_ready, !st.div_busy, "input ready while divider busy")
  `SLS_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "second sample taken before first finished")
  `SLS_ASSERT_NOW(a_out_rise, clk, rst, $rose(out_valid), $past(cmd.wrap && st.per_done), "result raised outside a period end")
  `SLS_ASSERT_NOW(a_wrap_free, clk, rst, cmd.wrap && st.per_done, st.out_free, "period result overwrote a pending result")

endmodule

`default_nettype wire
